// ===== design/mmh_pkg.sv =====
// ----------------------------------------------------------------------------
// mmh_pkg: shared constants for the 64-bit murmur hash block
// Mixing multiplier, finalizer shifts, seed reset value and register map.
// ----------------------------------------------------------------------------
package mmh_pkg;

  localparam logic [31:0] SEED_RESET = 32'h1987_1016;
  localparam logic [31:0] MIX_MUL    = 32'h5bd1_e995;

  localparam int MIX_SHIFT = 24;
  localparam int FIN_SH0   = 18;
  localparam int FIN_SH1   = 22;
  localparam int FIN_SH2   = 17;
  localparam int FIN_SH3   = 19;

  localparam int MAX_KEY_BYTES_DEF = 255;

  localparam int CFG_ADDR_W = 3;
  localparam logic REG_HASH_SEED = 1'b0;

endpackage

// ===== design/mmh_core.sv =====
// ----------------------------------------------------------------------------
// mmh_core: word sequencer and shared multiplier
// Seeds, mixes and finalizes one key word per beat over a small state
// machine that runs every product through one 32x32 multiplier.
// ----------------------------------------------------------------------------
module mmh_core #(
  parameter int MAX_KEY_BYTES = mmh_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] hash_seed,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_key_word,
  input  logic [7:0]  in_key_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash_value
);

  localparam int LenCap = (MAX_KEY_BYTES > 255) ? 255 : MAX_KEY_BYTES;
  localparam logic [7:0] LEN_CAP = 8'(LenCap);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_W0   = 4'd1;
  localparam logic [3:0] ST_W1   = 4'd2;
  localparam logic [3:0] ST_W2   = 4'd3;
  localparam logic [3:0] ST_TAIL = 4'd4;
  localparam logic [3:0] ST_F0   = 4'd5;
  localparam logic [3:0] ST_F1   = 4'd6;
  localparam logic [3:0] ST_F2   = 4'd7;
  localparam logic [3:0] ST_F3   = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [3:0]  state_r, state_nxt;
  logic [31:0] h1_r, h1_nxt;
  logic [31:0] h2_r, h2_nxt;
  logic [31:0] k_r, k_nxt;
  logic [7:0]  bl_r, bl_nxt;
  logic        lane_r, lane_nxt;
  logic        in_key_r, in_key_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_hash_r, out_hash_nxt;

  logic        accept;
  logic [7:0]  len;
  logic [7:0]  eff_bl;
  logic [31:0] tail_mask;
  logic [31:0] mul_a;
  logic [31:0] mul_res;
  logic        slot_free;

  assign in_stall       = (state_r != ST_IDLE);
  assign accept         = in_valid && (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;
  assign slot_free      = !out_valid_r || !out_stall;

  assign len    = (in_key_length > LEN_CAP) ? LEN_CAP : in_key_length;
  assign eff_bl = in_key_r ? bl_r : len;

  always_comb begin
    case (bl_r[1:0])
      2'd1:    tail_mask = 32'h0000_00ff;
      2'd2:    tail_mask = 32'h0000_ffff;
      2'd3:    tail_mask = 32'h00ff_ffff;
      default: tail_mask = 32'h0000_0000;
    endcase
  end

  always_comb begin
    unique case (state_r)
      ST_W0:   mul_a = k_r;
      ST_W1:   mul_a = k_r ^ (k_r >> mmh_pkg::MIX_SHIFT);
      ST_W2:   mul_a = lane_r ? h2_r : h1_r;
      ST_TAIL: mul_a = h2_r ^ (k_r & tail_mask);
      ST_F0:   mul_a = h1_r ^ (h2_r >> mmh_pkg::FIN_SH0);
      ST_F1:   mul_a = h2_r ^ (h1_r >> mmh_pkg::FIN_SH1);
      ST_F2:   mul_a = h1_r ^ (h2_r >> mmh_pkg::FIN_SH2);
      ST_F3:   mul_a = h2_r ^ (h1_r >> mmh_pkg::FIN_SH3);
      default: mul_a = 32'h0;
    endcase
  end

  assign mul_res = mul_a * mmh_pkg::MIX_MUL;

  always_comb begin
    state_nxt     = state_r;
    h1_nxt        = h1_r;
    h2_nxt        = h2_r;
    k_nxt         = k_r;
    bl_nxt        = bl_r;
    lane_nxt      = lane_r;
    in_key_nxt    = in_key_r;
    out_hash_nxt  = out_hash_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          k_nxt = in_key_word;
          if (!in_key_r) begin
            h1_nxt   = hash_seed ^ {24'h0, len};
            h2_nxt   = 32'h0;
            bl_nxt   = len;
            lane_nxt = 1'b0;
          end
          if (!in_key_r && (len == 8'd0)) begin
            state_nxt = ST_F0;
          end else if (eff_bl >= 8'd4) begin
            state_nxt = ST_W0;
          end else begin
            state_nxt = ST_TAIL;
          end
        end
      end
      ST_W0: begin
        k_nxt     = mul_res;
        state_nxt = ST_W1;
      end
      ST_W1: begin
        k_nxt     = mul_res;
        state_nxt = ST_W2;
      end
      ST_W2: begin
        if (lane_r) begin
          h2_nxt = mul_res ^ k_r;
        end else begin
          h1_nxt = mul_res ^ k_r;
        end
        bl_nxt = bl_r - 8'd4;
        if (bl_r == 8'd4) begin
          lane_nxt   = 1'b0;
          in_key_nxt = 1'b0;
          state_nxt  = ST_F0;
        end else begin
          lane_nxt   = !lane_r;
          in_key_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_TAIL: begin
        h2_nxt     = mul_res;
        bl_nxt     = 8'd0;
        lane_nxt   = 1'b0;
        in_key_nxt = 1'b0;
        state_nxt  = ST_F0;
      end
      ST_F0: begin
        h1_nxt    = mul_res;
        state_nxt = ST_F1;
      end
      ST_F1: begin
        h2_nxt    = mul_res;
        state_nxt = ST_F2;
      end
      ST_F2: begin
        h1_nxt    = mul_res;
        state_nxt = ST_F3;
      end
      ST_F3: begin
        h2_nxt    = mul_res;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          out_hash_nxt  = {h1_r, h2_r};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      h1_r        <= 32'h0;
      h2_r        <= 32'h0;
      bl_r        <= 8'd0;
      lane_r      <= 1'b0;
      in_key_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      h1_r        <= h1_nxt;
      h2_r        <= h2_nxt;
      bl_r        <= bl_nxt;
      lane_r      <= lane_nxt;
      in_key_r    <= in_key_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    out_hash_r <= out_hash_nxt;
  end

endmodule

// ===== design/murmur_hash_64b_top.sv =====
// ----------------------------------------------------------------------------
// murmur_hash_64b_top: streaming 64-bit murmur hash of byte keys
// Holds the seed register behind the configuration port and hashes keys
// delivered as little-endian words.
//
//   port group | direction | beat content
//   in_*       | input     | key_word (32), key_length (8, first word only)
//   out_*      | output    | hash_value (64), h1 high, h2 low
//   cfg_*      | APB       | hash_seed at byte address 0
//
// A full word is accepted and then makes three passes through the single
// shared multiplier; a tail word makes one. The last word of a key adds
// the four finalizer products and the output load.
// Reset clears the sequencer and loads the seed default; no clearing pass.
// in_stall is high while a word is in work; a stalled result holds in the
// output register and the next word is taken meanwhile.
// ----------------------------------------------------------------------------
module murmur_hash_64b_top #(
  parameter int MAX_KEY_BYTES = mmh_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [31:0]                 in_key_word,
  input  logic [7:0]                  in_key_length,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [63:0]                 out_hash_value,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [mmh_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  logic [31:0] seed_r, seed_nxt;
  logic        cfg_wr;
  logic        sel_seed;

  assign cfg_pready = 1'b1;
  assign sel_seed   = (cfg_paddr[2] == mmh_pkg::REG_HASH_SEED);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign seed_nxt   = (cfg_wr && sel_seed) ? cfg_pwdata : seed_r;
  assign cfg_prdata = sel_seed ? seed_r : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= mmh_pkg::SEED_RESET;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  mmh_core #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .hash_seed     (seed_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_key_word   (in_key_word),
    .in_key_length (in_key_length),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hash_value(out_hash_value)
  );

endmodule
